// ----- rtl/upi_pkg.sv -----
// Shared types, constants and the arctangent table of the pose integrator.
package upi_pkg;

  localparam int CordicSteps = 16;
  localparam int IterW = (CordicSteps > 1) ? $clog2(CordicSteps) : 1;

  localparam logic [33:0] GainQ30       = 34'd652032874;
  localparam logic [33:0] InvTwoPiQ32   = 34'd683565276;
  localparam logic [15:0] StepTimeMin   = 16'd66;
  localparam logic [15:0] StepTimeReset = 16'd3277;

  typedef logic [1:0] mul_sel_t;
  localparam mul_sel_t MulCos = 2'd0;
  localparam mul_sel_t MulSin = 2'd1;
  localparam mul_sel_t MulHdg = 2'd2;

  typedef struct packed {
    logic             accept;    // latch the item and seed the rotator
    logic             iter;      // one rotator iteration
    logic [IterW-1:0] iter_idx;
    logic             mul_en;
    mul_sel_t         mul_sel;
    logic             cap_x;
    logic             cap_y;
    logic             cap_h;
    logic             commit;    // move the new pose into the pose registers
  } upi_cmd_t;

  // arctan(2^-i) in 2^-32 turn units
  function automatic logic [31:0] atan_turns(input logic [4:0] idx);
    logic [31:0] r;
    case (idx)
      5'd0:    r = 32'd536870912;
      5'd1:    r = 32'd316933406;
      5'd2:    r = 32'd167458907;
      5'd3:    r = 32'd85004756;
      5'd4:    r = 32'd42667331;
      5'd5:    r = 32'd21354465;
      5'd6:    r = 32'd10679838;
      5'd7:    r = 32'd5340245;
      5'd8:    r = 32'd2670163;
      5'd9:    r = 32'd1335087;
      5'd10:   r = 32'd667544;
      5'd11:   r = 32'd333772;
      5'd12:   r = 32'd166886;
      5'd13:   r = 32'd83443;
      5'd14:   r = 32'd41722;
      5'd15:   r = 32'd20861;
      5'd16:   r = 32'd10430;
      5'd17:   r = 32'd5215;
      5'd18:   r = 32'd2608;
      5'd19:   r = 32'd1304;
      5'd20:   r = 32'd652;
      5'd21:   r = 32'd326;
      5'd22:   r = 32'd163;
      5'd23:   r = 32'd81;
      default: r = 32'd0;
    endcase
    return r;
  endfunction

endpackage

// ----- rtl/upi_ctrl.sv -----
// Sequencer of the pose integrator: handshakes, rotator count, multiply order.
module upi_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic             action_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output upi_pkg::upi_cmd_t cmd_o
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_ITER   = 3'd1;
  localparam logic [2:0] S_MULC   = 3'd2;
  localparam logic [2:0] S_MULS   = 3'd3;
  localparam logic [2:0] S_MULH   = 3'd4;
  localparam logic [2:0] S_HDG    = 3'd5;
  localparam logic [2:0] S_COMMIT = 3'd6;

  localparam logic [upi_pkg::IterW-1:0] IterLast =
    upi_pkg::IterW'(upi_pkg::CordicSteps - 1);

  logic [2:0]                state_q, state_d;
  logic [upi_pkg::IterW-1:0] iter_q, iter_d;
  logic                      out_valid_q, out_valid_d;
  logic                      in_acc;
  logic                      slot_free;

  assign in_ready_o  = (state_q == S_IDLE);
  assign in_acc      = in_valid_i & in_ready_o;
  assign slot_free   = ~out_valid_q | out_ready_i;
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d        = state_q;
    iter_d         = iter_q;
    cmd_o          = '0;
    cmd_o.iter_idx = iter_q;
    cmd_o.mul_sel  = upi_pkg::MulCos;
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          cmd_o.accept = 1'b1;
          iter_d       = '0;
          state_d      = action_i ? S_ITER : S_COMMIT;
        end
      end
      S_ITER: begin
        cmd_o.iter = 1'b1;
        iter_d     = iter_q + 1'b1;
        if (iter_q == IterLast) begin
          state_d = S_MULC;
        end
      end
      S_MULC: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = upi_pkg::MulCos;
        state_d       = S_MULS;
      end
      S_MULS: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = upi_pkg::MulSin;
        cmd_o.cap_x   = 1'b1;
        state_d       = S_MULH;
      end
      S_MULH: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = upi_pkg::MulHdg;
        cmd_o.cap_y   = 1'b1;
        state_d       = S_HDG;
      end
      S_HDG: begin
        cmd_o.cap_h = 1'b1;
        state_d     = S_COMMIT;
      end
      S_COMMIT: begin
        // hold until the previous result has been taken
        if (slot_free) begin
          cmd_o.commit = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign out_valid_d = cmd_o.commit | (out_valid_q & ~out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      iter_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      iter_q      <= iter_d;
      out_valid_q <= out_valid_d;
    end
  end

  a_commit_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.commit |-> (!out_valid_q || out_ready_i))
    else $error("pose committed over an untaken result");

  a_commit_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.commit |=> out_valid_q)
    else $error("committed pose not presented");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !in_ready_o)
    else $error("second item taken while busy");

  a_iter_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ITER) |-> (iter_q <= IterLast))
    else $error("rotator count out of range");

endmodule

// ----- rtl/upi_datapath.sv -----
// Datapath of the pose integrator: pose registers, CORDIC rotator, shared multiplier.
module upi_datapath (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  upi_pkg::upi_cmd_t         cmd_i,
  input  logic                     step_time_we_i,
  input  logic [15:0]              step_time_i,
  input  logic signed [31:0]       start_x_i,
  input  logic signed [31:0]       start_y_i,
  input  logic [15:0]              start_heading_i,
  input  logic signed [15:0]       speed_i,
  input  logic signed [15:0]       turn_rate_i,
  output logic signed [31:0]       pose_x_o,
  output logic signed [31:0]       pose_y_o,
  output logic [15:0]              pose_heading_o
);

  logic [15:0]        step_time_q;
  logic signed [31:0] pos_x_q, pos_y_q;
  logic [15:0]        hdg_q;
  logic signed [31:0] nx_q, ny_q;
  logic [15:0]        nh_q;
  logic signed [32:0] vdt_q, wdt_q;
  logic signed [33:0] cx_q, cy_q;
  logic signed [32:0] cz_q;
  logic               flip_q;
  logic signed [63:0] prod_q;

  // step setup
  logic signed [16:0] dt_s;
  logic [15:0]        hdg_q1;
  logic               flip_d;
  logic [31:0]        ang;

  // rotator
  logic signed [33:0] xs, ys;
  logic signed [32:0] at;

  // multiplier and rounding
  logic signed [32:0] ma;
  logic signed [33:0] mb;
  logic signed [66:0] prod_full;
  logic signed [63:0] rnd_p, rnd_h;
  logic signed [21:0] disp;
  logic signed [33:0] psum;
  logic signed [31:0] pbase;
  logic signed [31:0] psat;

  assign dt_s   = $signed({1'b0, step_time_q});
  assign hdg_q1 = hdg_q + 16'h4000;
  assign flip_d = hdg_q1[15];
  // half-turn flip brings the angle into [-90, +90) degrees
  assign ang    = {hdg_q ^ {flip_d, 15'd0}, 16'd0};

  assign xs = cx_q >>> cmd_i.iter_idx;
  assign ys = cy_q >>> cmd_i.iter_idx;
  assign at = $signed({1'b0, upi_pkg::atan_turns(5'(cmd_i.iter_idx))});

  always_comb begin
    ma = vdt_q;
    mb = flip_q ? -cx_q : cx_q;
    case (cmd_i.mul_sel)
      upi_pkg::MulCos: mb = flip_q ? -cx_q : cx_q;
      upi_pkg::MulSin: mb = flip_q ? -cy_q : cy_q;
      upi_pkg::MulHdg: begin
        ma = wdt_q;
        mb = $signed(upi_pkg::InvTwoPiQ32);
      end
      default: mb = '0;
    endcase
  end

  assign prod_full = 67'(ma) * 67'(mb);

  // round half up to Q16.16 and saturate the new position
  assign rnd_p = prod_q + (64'sd1 <<< 41);
  assign disp  = rnd_p[63:42];
  assign pbase = cmd_i.cap_y ? pos_y_q : pos_x_q;
  assign psum  = 34'(pbase) + 34'(disp);

  always_comb begin
    if (psum > 34'sd2147483647) begin
      psat = 32'sh7FFFFFFF;
    end else if (psum < -34'sd2147483648) begin
      psat = 32'sh80000000;
    end else begin
      psat = psum[31:0];
    end
  end

  assign rnd_h = prod_q + (64'sd1 <<< 43);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_time_q <= upi_pkg::StepTimeReset;
      pos_x_q     <= '0;
      pos_y_q     <= '0;
      hdg_q       <= '0;
    end else begin
      if (step_time_we_i) begin
        step_time_q <= (step_time_i < upi_pkg::StepTimeMin) ?
                       upi_pkg::StepTimeMin : step_time_i;
      end
      if (cmd_i.commit) begin
        pos_x_q <= nx_q;
        pos_y_q <= ny_q;
        hdg_q   <= nh_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      // load fields are taken as the new pose; a step overwrites them later
      nx_q   <= start_x_i;
      ny_q   <= start_y_i;
      nh_q   <= start_heading_i;
      vdt_q  <= 33'(speed_i) * 33'(dt_s);
      wdt_q  <= 33'(turn_rate_i) * 33'(dt_s);
      cx_q   <= $signed(upi_pkg::GainQ30);
      cy_q   <= '0;
      cz_q   <= 33'($signed(ang));
      flip_q <= flip_d;
    end
    if (cmd_i.iter) begin
      if (!cz_q[32]) begin
        cx_q <= cx_q - ys;
        cy_q <= cy_q + xs;
        cz_q <= cz_q - at;
      end else begin
        cx_q <= cx_q + ys;
        cy_q <= cy_q - xs;
        cz_q <= cz_q + at;
      end
    end
    if (cmd_i.mul_en) begin
      prod_q <= prod_full[63:0];
    end
    if (cmd_i.cap_x) begin
      nx_q <= psat;
    end
    if (cmd_i.cap_y) begin
      ny_q <= psat;
    end
    if (cmd_i.cap_h) begin
      nh_q <= hdg_q + rnd_h[59:44];
    end
  end

  assign pose_x_o       = pos_x_q;
  assign pose_y_o       = pos_y_q;
  assign pose_heading_o = hdg_q;

endmodule

// ----- rtl/unicycle_pose_integrator_core.sv -----
// Top level of the unicycle pose integrator.
// Dead-reckons a unicycle pose in fixed point. A load item (action 0) sets
// x, y and heading and presents them unchanged once the commit state finds
// the output slot free; the next item can be taken after that commit. A step item
// (action 1) rotates by the current heading with a single shared CORDIC stage
// of CordicSteps iterations, then runs three multiplies in turn through one
// multiplier (speed*dt by cos and by sin, turn_rate*dt by 1/(2*pi)) before it
// commits the same way. Positions are Q16.16 and saturate; the heading is a
// 16-bit binary angle that wraps. One item is worked on at a time; the pose
// registers double as the output register, so a new item is accepted while the
// last result is still waiting. step_time is to be written through its enable
// only at idle times, which the block itself does not enforce; values below
// 66 are stored as 66.
module unicycle_pose_integrator_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               step_time_we_i,
  input  logic [15:0]        step_time_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               action_i,
  input  logic signed [31:0] start_x_i,
  input  logic signed [31:0] start_y_i,
  input  logic [15:0]        start_heading_i,
  input  logic signed [15:0] speed_i,
  input  logic signed [15:0] turn_rate_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] pose_x_o,
  output logic signed [31:0] pose_y_o,
  output logic [15:0]        pose_heading_o
);

  upi_pkg::upi_cmd_t cmd;

  upi_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .action_i    (action_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd)
  );

  upi_datapath u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .step_time_we_i  (step_time_we_i),
    .step_time_i     (step_time_i),
    .start_x_i       (start_x_i),
    .start_y_i       (start_y_i),
    .start_heading_i (start_heading_i),
    .speed_i         (speed_i),
    .turn_rate_i     (turn_rate_i),
    .pose_x_o        (pose_x_o),
    .pose_y_o        (pose_y_o),
    .pose_heading_o  (pose_heading_o)
  );

endmodule

// ----- tb/unicycle_pose_integrator_core_tb.sv -----
// Self-checking testbench for the unicycle pose integrator core.
`timescale 1ns / 100ps

module unicycle_pose_integrator_core_tb;

  localparam int CycleLimit   = 600000;
  localparam int HoldCycles   = 400;
  localparam int SettleCycles = 4 * (upi_pkg::CordicSteps + 6);
  localparam int RotSteps     = (upi_pkg::CordicSteps > 24) ? 24 : upi_pkg::CordicSteps;
  localparam int MaxReports   = 60;

  localparam longint CordicGain = 64'sd652032874;
  localparam longint InvTwoPi   = 64'sd683565276;
  localparam longint DispRound  = 64'sd2199023255552;   // 2^41
  localparam longint HdgRound   = 64'sd8796093022208;   // 2^43
  localparam longint PosMax     = 64'sd2147483647;
  localparam longint PosMin     = -64'sd2147483648;

  localparam logic ActLoad = 1'b0;
  localparam logic ActStep = 1'b1;

  // arctan(2^-i) in 2^-32 turn units, element 0 leftmost
  localparam logic [0:23][31:0] AtanTurns = {
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
    32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
    32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
    32'd166886,    32'd83443,     32'd41722,     32'd20861,
    32'd10430,     32'd5215,      32'd2608,      32'd1304,
    32'd652,       32'd326,       32'd163,       32'd81
  };

  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    logic [15:0] hdg;
  } pose_t;

  logic               clk_i          = 1'b0;
  logic               rst_ni         = 1'b0;
  logic               step_time_we_i = 1'b0;
  logic [15:0]        step_time_i    = 16'd0;
  logic               in_valid_i     = 1'b0;
  logic               action_i       = ActLoad;
  logic signed [31:0] start_x_i      = 32'sd0;
  logic signed [31:0] start_y_i      = 32'sd0;
  logic [15:0]        start_heading_i = 16'd0;
  logic signed [15:0] speed_i        = 16'sd0;
  logic signed [15:0] turn_rate_i    = 16'sd0;
  logic               out_ready_i    = 1'b0;
  logic               in_ready_o;
  logic               out_valid_o;
  logic signed [31:0] pose_x_o;
  logic signed [31:0] pose_y_o;
  logic [15:0]        pose_heading_o;

  // tracked pose and step time
  logic [31:0] trk_x   = 32'd0;
  logic [31:0] trk_y   = 32'd0;
  logic [15:0] trk_hdg = 16'd0;
  logic [15:0] trk_dt  = upi_pkg::StepTimeReset;

  pose_t pose_expected_q[$];
  pose_t pose_want;

  int cycle_cnt      = 0;
  int err_cnt        = 0;
  int poses_checked  = 0;
  int items_sent     = 0;
  int loads_sent     = 0;
  int dt_settings    = 0;
  int rx_hold_reqs   = 0;
  int rx_hold_served = 0;
  int rx_hold_left   = 0;
  int rx_slot        = 0;
  int rx_mode        = 0;
  logic [31:0] rx_mask = 32'd0;

  unicycle_pose_integrator_core u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .step_time_we_i  (step_time_we_i),
    .step_time_i     (step_time_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .action_i        (action_i),
    .start_x_i       (start_x_i),
    .start_y_i       (start_y_i),
    .start_heading_i (start_heading_i),
    .speed_i         (speed_i),
    .turn_rate_i     (turn_rate_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .pose_x_o        (pose_x_o),
    .pose_y_o        (pose_y_o),
    .pose_heading_o  (pose_heading_o)
  );

  always #2 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= CycleLimit) begin
      $display("%0t: run exceeded %0d cycles with %0d poses outstanding", $time,
               CycleLimit, pose_expected_q.size());
      $display("TB_ERROR");
      $finish;
    end
  end

  // Receiver: a long hold on request, otherwise a stall pattern renewed whenever the slot counter wraps.
  always @(posedge clk_i) begin
    if (rx_hold_served != rx_hold_reqs && rx_hold_left == 0) begin
      rx_hold_left = HoldCycles;
      rx_hold_served++;
    end
    if (rx_hold_left != 0) begin
      rx_hold_left--;
      out_ready_i <= 1'b0;
    end else begin
      if (rx_slot == 0) begin
        rx_mode = $urandom_range(0, 3);
        rx_mask = $urandom;
      end
      rx_slot = (rx_slot + 1) % 32;
      case (rx_mode)
        0: begin
          out_ready_i <= 1'b1;
        end
        1: begin
          out_ready_i <= rx_mask[rx_slot];
        end
        2: begin
          out_ready_i <= rx_mask[rx_slot] | rx_mask[(rx_slot + 7) % 32];
        end
        default: begin
          out_ready_i <= rx_slot[3];
        end
      endcase
    end
  end

  // Compare each accepted pose with the oldest one predicted.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o === 1'b1 && out_ready_i) begin
      if (pose_expected_q.size() == 0) begin
        err_cnt++;
        if (err_cnt <= MaxReports)
          $display("%0t: unexpected pose item, expected none, actual x %0d y %0d heading %0d",
                   $time, pose_x_o, pose_y_o, pose_heading_o);
      end else begin
        pose_want = pose_expected_q.pop_front();
        poses_checked++;
        if (pose_x_o !== pose_want.x) begin
          err_cnt++;
          if (err_cnt <= MaxReports)
            $display("%0t: pose_x mismatch, expected %0d, actual %0d", $time,
                     $signed(pose_want.x), pose_x_o);
        end
        if (pose_y_o !== pose_want.y) begin
          err_cnt++;
          if (err_cnt <= MaxReports)
            $display("%0t: pose_y mismatch, expected %0d, actual %0d", $time,
                     $signed(pose_want.y), pose_y_o);
        end
        if (pose_heading_o !== pose_want.hdg) begin
          err_cnt++;
          if (err_cnt <= MaxReports)
            $display("%0t: pose_heading mismatch, expected %0d, actual %0d", $time,
                     pose_want.hdg, pose_heading_o);
        end
      end
    end
  end

  // Offer one item, wait for it to be taken, then advance the tracked pose.
  task automatic offer_item(input logic act, input logic [31:0] sx, input logic [31:0] sy,
                            input logic [15:0] sh, input logic [15:0] sp,
                            input logic [15:0] tr);
    logic [16:0]        quad;
    logic               flip;
    logic [31:0]        ang;
    logic signed [63:0] cx, cy, cz, xs, ys, vv, ww, dt, dx, dy, dh, nx, ny;
    int                 i;
    pose_t              exp_pose;
    action_i        <= act;
    start_x_i       <= sx;
    start_y_i       <= sy;
    start_heading_i <= sh;
    speed_i         <= sp;
    turn_rate_i     <= tr;
    in_valid_i      <= 1'b1;
    @(posedge clk_i);
    while (in_ready_o !== 1'b1) @(posedge clk_i);
    items_sent++;
    if (act == ActLoad) begin
      loads_sent++;
      trk_x   = sx;
      trk_y   = sy;
      trk_hdg = sh;
    end else begin
      // fold the heading into [-90, +90) degrees and undo the half turn afterwards
      quad = {1'b0, trk_hdg} + 17'h04000;
      flip = quad[15];
      ang  = {trk_hdg, 16'h0000};
      if (flip) ang = ang + 32'h8000_0000;
      cz = {{32{ang[31]}}, ang};
      cx = CordicGain;
      cy = 64'sd0;
      for (i = 0; i < RotSteps; i++) begin
        xs = cx >>> i;
        ys = cy >>> i;
        if (cz >= 0) begin
          cx = cx - ys;
          cy = cy + xs;
          cz = cz - AtanTurns[i];
        end else begin
          cx = cx + ys;
          cy = cy - xs;
          cz = cz + AtanTurns[i];
        end
      end
      if (flip) begin
        cx = -cx;
        cy = -cy;
      end
      vv = {{48{sp[15]}}, sp};
      ww = {{48{tr[15]}}, tr};
      dt = {48'd0, trk_dt};
      dx = (vv * cx * dt + DispRound) >>> 42;
      dy = (vv * cy * dt + DispRound) >>> 42;
      nx = {{32{trk_x[31]}}, trk_x} + dx;
      ny = {{32{trk_y[31]}}, trk_y} + dy;
      if (nx > PosMax) nx = PosMax;
      else if (nx < PosMin) nx = PosMin;
      if (ny > PosMax) ny = PosMax;
      else if (ny < PosMin) ny = PosMin;
      trk_x = nx[31:0];
      trk_y = ny[31:0];
      // the fraction of a heading unit is rounded half up here
      dh = (ww * dt * InvTwoPi + HdgRound) >>> 44;
      trk_hdg = trk_hdg + dh[15:0];
    end
    exp_pose.x   = trk_x;
    exp_pose.y   = trk_y;
    exp_pose.hdg = trk_hdg;
    pose_expected_q.insert(pose_expected_q.size(), exp_pose);
  endtask

  task automatic offer_random_item();
    logic        act;
    logic [31:0] sx, sy, rnd;
    logic [15:0] sp, tr;
    act = ($urandom_range(0, 9) != 0) ? ActStep : ActLoad;
    rnd = $urandom;
    sx  = $urandom;
    sy  = $urandom;
    case ($urandom_range(0, 7))
      0: sx = {16'h7FFF, rnd[15:0]};
      1: sx = {16'h8000, rnd[15:0]};
      2: sy = {16'h7FFF, rnd[31:16]};
      3: sy = {16'h8000, rnd[31:16]};
      default: ;
    endcase
    rnd = $urandom;
    case ($urandom_range(0, 5))
      0: sp = 16'h7FFF;
      1: sp = 16'h8000;
      2: sp = {{8{rnd[8]}}, rnd[7:0]};
      default: sp = rnd[15:0];
    endcase
    case ($urandom_range(0, 5))
      0: tr = 16'h7FFF;
      1: tr = 16'h8000;
      2: tr = {{8{rnd[24]}}, rnd[23:16]};
      default: tr = rnd[31:16];
    endcase
    offer_item(act, sx, sy, 16'($urandom), sp, tr);
  endtask

  // Hold the sender off until every predicted pose has been taken.
  task automatic drain_poses();
    in_valid_i <= 1'b0;
    while (pose_expected_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic set_step_time(input logic [15:0] value);
    drain_poses();
    step_time_i    <= value;
    step_time_we_i <= 1'b1;
    @(posedge clk_i);
    step_time_we_i <= 1'b0;
    trk_dt = (value < upi_pkg::StepTimeMin) ? upi_pkg::StepTimeMin : value;
    dt_settings++;
  endtask

  task automatic test_load_echo();
    offer_item(ActLoad, 32'h7FFF_FFFF, 32'h8000_0000, 16'hFFFF, 16'h7FFF, 16'h8000);
    offer_item(ActLoad, 32'h8000_0000, 32'h7FFF_FFFF, 16'h0000, 16'h8000, 16'h7FFF);
    offer_item(ActLoad, 32'h0000_0000, 32'h0000_0000, 16'h8000, 16'h0000, 16'h0000);
  endtask

  // Step from either side of each quarter-turn boundary of the heading fold.
  task automatic test_heading_quadrants();
    logic [15:0] hdg_list [4];
    int          k;
    hdg_list = '{16'h3FFF, 16'h4000, 16'hBFFF, 16'hC000};
    for (k = 0; k < 4; k++) begin
      offer_item(ActLoad, 32'h0001_0000, 32'hFFFF_0000, hdg_list[k], 16'h0000, 16'h0000);
      offer_item(ActStep, 32'($urandom), 32'($urandom), 16'($urandom),
                 k[0] ? 16'h8000 : 16'h7FFF, k[1] ? 16'h8000 : 16'h7FFF);
    end
  endtask

  task automatic test_position_saturation();
    set_step_time(16'hFFFF);
    offer_item(ActLoad, 32'h7FFF_0000, 32'h8001_0000, 16'h0000, 16'h0000, 16'h0000);
    offer_item(ActStep, 32'h0, 32'h0, 16'h0, 16'h7FFF, 16'h0000);
    offer_item(ActLoad, 32'h0000_0000, 32'h7FFF_8000, 16'h4000, 16'h0000, 16'h0000);
    offer_item(ActStep, 32'h0, 32'h0, 16'h0, 16'h7FFF, 16'h0000);
    offer_item(ActLoad, 32'h8000_0100, 32'h8000_0000, 16'h8000, 16'h0000, 16'h0000);
    offer_item(ActStep, 32'h0, 32'h0, 16'h0, 16'h7FFF, 16'h0000);
  endtask

  // Writes below the floor store the floor; tiny turn rates lose their fraction.
  task automatic test_step_time_floor();
    set_step_time(16'd0);
    offer_item(ActStep, 32'h0, 32'h0, 16'h0, 16'h7FFF, 16'h7FFF);
    set_step_time(16'd65);
    offer_item(ActStep, 32'h0, 32'h0, 16'h0, 16'h8000, 16'h0001);
    set_step_time(upi_pkg::StepTimeMin);
    offer_item(ActStep, 32'h0, 32'h0, 16'h0, 16'h0400, 16'hFFFF);
  endtask

  task automatic test_heading_wrap();
    set_step_time(16'hFFFF);
    offer_item(ActLoad, 32'h0000_0000, 32'h0000_0000, 16'hFFF0, 16'h0000, 16'h0000);
    offer_item(ActStep, 32'h0, 32'h0, 16'h0, 16'h1000, 16'h7FFF);
    offer_item(ActStep, 32'h0, 32'h0, 16'h0, 16'hF000, 16'h8000);
  endtask

  // Stall the receiver for a long stretch while items keep coming.
  task automatic test_backpressure();
    int k;
    rx_hold_reqs++;
    for (k = 0; k < 12; k++) offer_random_item();
    drain_poses();
  endtask

  task automatic test_random_traffic(input logic [15:0] dt_setting, input int count);
    int left, burst, gap;
    set_step_time(dt_setting);
    left = count;
    while (left > 0) begin
      burst = $urandom_range(1, 16);
      while (burst > 0 && left > 0) begin
        offer_random_item();
        burst--;
        left--;
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
      if ($urandom_range(0, 24) == 0) begin
        drain_poses();
      end else if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_load_echo();
    test_heading_quadrants();
    test_position_saturation();
    test_step_time_floor();
    test_heading_wrap();
    test_backpressure();
    test_random_traffic(16'($urandom_range(66, 65535)), 230);
    test_random_traffic(16'hFFFF, 230);
    test_random_traffic(16'd7, 230);
    test_random_traffic(upi_pkg::StepTimeReset, 100);
    test_random_traffic(16'($urandom), 130);

    drain_poses();
    repeat (SettleCycles) @(posedge clk_i);

    $display("Sent %0d items (%0d loads, %0d steps) across %0d step_time writes;",
             items_sent, loads_sent, items_sent - loads_sent, dt_settings);
    $display("checked %0d poses with %0d mismatches, including a %0d-cycle output stall.",
             poses_checked, err_cnt, HoldCycles);
    if (err_cnt == 0 && pose_expected_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
